// ===== design/lng_pkg.sv =====
// Shared types and constants for the lattice neighbor index generator.
`default_nettype none

package lng_pkg;

    // Default sizing of the lattice.
    localparam int LNG_MAX_DIMS   = 4;
    localparam int LNG_MAX_EXTENT = 16;

    // Fixed widths of the register file and result fields.
    localparam int NUM_EXT  = 4;
    localparam int DIMS_W   = 3;
    localparam int EXT_W    = 5;
    localparam int EXT_M1_W = 8;
    localparam int SITE_W   = 16;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 3;

    // Register indexes (byte address is four times the index).
    typedef enum logic [REG_IDX_W-1:0] {
        REG_DIMS   = 3'd0,
        REG_EXT_D1 = 3'd1,
        REG_EXT_D2 = 3'd2,
        REG_EXT_D3 = 3'd3,
        REG_EXT_D4 = 3'd4
    } t_reg_idx;

    // Lattice geometry handed from the register block to the walker.
    typedef struct packed {
        logic                                busy;
        logic                                walk_clr;
        logic [NUM_EXT-1:0]                  act;
        logic [NUM_EXT-1:0][EXT_M1_W-1:0]    ext_m1;
        logic [NUM_EXT-1:0][SITE_W-1:0]      stride;
        logic [NUM_EXT-1:0][SITE_W-1:0]      wrap;
    } t_lat_cfg;

endpackage

`default_nettype wire

// ===== design/lng_cfg.sv =====
// Register file and stride pipeline of the lattice neighbor index generator.
`default_nettype none

module lng_cfg
    import lng_pkg::*;
#(
    parameter int MAX_DIMS   = LNG_MAX_DIMS,
    parameter int MAX_EXTENT = LNG_MAX_EXTENT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_lat_cfg               o_cfg
);

    // Cycles until strides and wrap distances reflect a new configuration.
    localparam int SETTLE   = MAX_DIMS + 1;
    localparam int SETTLE_W = $clog2(SETTLE + 1);

    logic [DIMS_W-1:0]              r_dims;
    logic [NUM_EXT-1:0][EXT_W-1:0]  r_ext;
    logic [SETTLE_W-1:0]            r_settle;
    logic [SETTLE_W-1:0]            n_settle;
    logic [SITE_W-1:0]              r_stride [MAX_DIMS+1];
    logic [SITE_W-1:0]              r_wrap   [MAX_DIMS];

    logic                           wr_en;
    logic                           wr_listed;
    t_reg_idx                       wr_idx;
    logic [NUM_EXT-1:0][EXT_M1_W-1:0] ext_m1;
    logic [NUM_EXT-1:0]             act;
    logic [DIMS_W-1:0]              nd;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign wr_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    // Only the listed registers take a write; each such write restarts the walk.
    always_comb begin
        wr_listed = 1'b0;
        if (wr_en) begin
            unique case (wr_idx)
                REG_DIMS, REG_EXT_D1, REG_EXT_D2, REG_EXT_D3, REG_EXT_D4: begin
                    wr_listed = 1'b1;
                end
                default: begin
                    wr_listed = 1'b0;
                end
            endcase
        end
    end

    // Register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_W'(NUM_EXT);
            for (int k = 0; k < NUM_EXT; k++) begin
                r_ext[k] <= EXT_W'(4);
            end
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_DIMS:   r_dims   <= pwdata[DIMS_W-1:0];
                REG_EXT_D1: r_ext[0] <= pwdata[EXT_W-1:0];
                REG_EXT_D2: r_ext[1] <= pwdata[EXT_W-1:0];
                REG_EXT_D3: r_ext[2] <= pwdata[EXT_W-1:0];
                REG_EXT_D4: r_ext[3] <= pwdata[EXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back the raw register values.
    always_comb begin
        prdata = '0;
        unique case (wr_idx)
            REG_DIMS:   prdata = DATA_W'(r_dims);
            REG_EXT_D1: prdata = DATA_W'(r_ext[0]);
            REG_EXT_D2: prdata = DATA_W'(r_ext[1]);
            REG_EXT_D3: prdata = DATA_W'(r_ext[2]);
            REG_EXT_D4: prdata = DATA_W'(r_ext[3]);
            default:    prdata = '0;
        endcase
    end

    // Clamp the extents to 1..MAX_EXTENT and keep them as extent minus one.
    always_comb begin
        for (int k = 0; k < NUM_EXT; k++) begin
            if (r_ext[k] == '0) begin
                ext_m1[k] = '0;
            end else if (32'(r_ext[k]) > 32'(MAX_EXTENT)) begin
                ext_m1[k] = EXT_M1_W'(MAX_EXTENT - 1);
            end else begin
                ext_m1[k] = EXT_M1_W'(r_ext[k] - EXT_W'(1));
            end
        end
    end

    // Clamp the dimension count to 1..MAX_DIMS and build the active mask.
    always_comb begin
        if (r_dims == '0) begin
            nd = DIMS_W'(1);
        end else if (32'(r_dims) > 32'(MAX_DIMS)) begin
            nd = DIMS_W'(MAX_DIMS);
        end else begin
            nd = r_dims;
        end
        for (int k = 0; k < NUM_EXT; k++) begin
            act[k] = (32'(nd) > k);
        end
    end

    // Stride chain: one multiplication per register stage. The unit stride
    // is loaded on every clock, so it holds long before reset ends.
    always_ff @(posedge i_clk) begin
        r_stride[0] <= SITE_W'(1);
        for (int k = 0; k < MAX_DIMS; k++) begin
            r_stride[k+1] <= SITE_W'(r_stride[k] * SITE_W'({1'b0, ext_m1[k]} + 9'd1));
            r_wrap[k]     <= r_stride[k+1] - r_stride[k];
        end
    end

    // Settle counter holds off items while the stride chain catches up.
    always_comb begin
        n_settle = r_settle;
        if (wr_listed) begin
            n_settle = SETTLE_W'(SETTLE);
        end else if (r_settle != '0) begin
            n_settle = r_settle - SETTLE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_W'(SETTLE);
        end else begin
            r_settle <= n_settle;
        end
    end

    // Geometry bundle for the walker.
    always_comb begin
        o_cfg          = '0;
        o_cfg.busy     = (r_settle != '0);
        o_cfg.walk_clr = wr_listed;
        o_cfg.act      = act;
        o_cfg.ext_m1   = ext_m1;
        for (int k = 0; k < MAX_DIMS; k++) begin
            o_cfg.stride[k] = r_stride[k];
            o_cfg.wrap[k]   = r_wrap[k];
        end
    end

    // A listed write always holds off items for the next cycles.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_listed |=> (r_settle != '0))
        else $error("write to a listed register did not start the settle count");

    // Once settled, the first stride beyond unity equals the first extent.
    a_stride_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settle == '0) |-> (r_stride[1] == SITE_W'({1'b0, ext_m1[0]} + 9'd1)))
        else $error("stride chain not settled when the block is free");

endmodule

`default_nettype wire

// ===== design/lng_step.sv =====
// Site walker and neighbor computation with its result register.
`default_nettype none

module lng_step
    import lng_pkg::*;
#(
    parameter int MAX_DIMS   = LNG_MAX_DIMS,
    parameter int MAX_EXTENT = LNG_MAX_EXTENT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_lat_cfg                        i_cfg,
    input  wire logic                            i_valid,
    input  wire logic                            i_restart,
    output logic                                 o_stall,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [SITE_W-1:0]                    o_site_index,
    output logic [NUM_EXT-1:0][SITE_W-1:0]       o_fwd_nb,
    output logic [NUM_EXT-1:0][SITE_W-1:0]       o_bwd_nb,
    output logic                                 o_on_boundary,
    output logic                                 o_last_site
);

    localparam int CW = $clog2(MAX_EXTENT);

    logic [CW-1:0]                   r_coord [MAX_DIMS];
    logic [SITE_W-1:0]               r_site;
    logic                            r_out_valid;
    logic [SITE_W-1:0]               r_site_index;
    logic [NUM_EXT-1:0][SITE_W-1:0]  r_fwd;
    logic [NUM_EXT-1:0][SITE_W-1:0]  r_bwd;
    logic                            r_boundary;
    logic                            r_last;

    logic                            accept;
    logic [NUM_EXT-1:0][CW-1:0]      base_c;
    logic [SITE_W-1:0]               base_site;
    logic [NUM_EXT-1:0]              at_top;
    logic [NUM_EXT-1:0]              at_zero;
    logic [NUM_EXT-1:0][SITE_W-1:0]  fwd;
    logic [NUM_EXT-1:0][SITE_W-1:0]  bwd;
    logic                            boundary;
    logic                            last;
    logic [NUM_EXT-1:0][CW-1:0]      n_coord;
    logic [SITE_W-1:0]               n_site;
    logic                            carry;

    // The result register frees up in the same cycle it is taken.
    assign o_stall = i_cfg.busy | (r_out_valid & i_stall);
    assign accept  = i_valid & ~o_stall;

    // Current site, or the origin on restart.
    always_comb begin
        base_c = '0;
        for (int k = 0; k < MAX_DIMS; k++) begin
            base_c[k] = i_restart ? '0 : r_coord[k];
        end
        base_site = i_restart ? '0 : r_site;
    end

    // Neighbors with periodic wrap, boundary and last-site flags.
    always_comb begin
        boundary = 1'b0;
        last     = 1'b1;
        for (int k = 0; k < NUM_EXT; k++) begin
            at_top[k]  = (base_c[k] == i_cfg.ext_m1[k][CW-1:0]);
            at_zero[k] = (base_c[k] == '0);
            fwd[k] = '0;
            bwd[k] = '0;
            if (i_cfg.act[k]) begin
                fwd[k] = at_top[k] ? base_site - i_cfg.wrap[k]
                                   : base_site + i_cfg.stride[k];
                bwd[k] = at_zero[k] ? base_site + i_cfg.wrap[k]
                                    : base_site - i_cfg.stride[k];
                boundary = boundary | at_top[k] | at_zero[k];
                last     = last & at_top[k];
            end
        end
    end

    // Advance the coordinates like an odometer, dimension one fastest.
    always_comb begin
        carry = 1'b1;
        for (int k = 0; k < NUM_EXT; k++) begin
            n_coord[k] = base_c[k];
            if (i_cfg.act[k] && carry) begin
                if (at_top[k]) begin
                    n_coord[k] = '0;
                end else begin
                    n_coord[k] = base_c[k] + CW'(1);
                    carry      = 1'b0;
                end
            end
        end
        n_site = last ? '0 : base_site + SITE_W'(1);
    end

    // Walk state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.walk_clr) begin
            for (int k = 0; k < MAX_DIMS; k++) begin
                r_coord[k] <= '0;
            end
            r_site <= '0;
        end else if (accept) begin
            for (int k = 0; k < MAX_DIMS; k++) begin
                r_coord[k] <= n_coord[k];
            end
            r_site <= n_site;
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_site_index <= base_site;
            r_fwd        <= fwd;
            r_bwd        <= bwd;
            r_boundary   <= boundary;
            r_last       <= last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_site_index  = r_site_index;
    assign o_fwd_nb      = r_fwd;
    assign o_bwd_nb      = r_bwd;
    assign o_on_boundary = r_boundary;
    assign o_last_site   = r_last;

    // The last site of the volume always lies on the boundary.
    a_last_on_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> r_boundary)
        else $error("last site reported off the boundary");

    // After the last site the walk returns to the origin.
    a_wrap_to_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> (r_site == '0))
        else $error("walk did not wrap to site zero after the last site");

    // The first coordinate never leaves the configured extent.
    a_coord_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg.busy |-> (r_coord[0] <= i_cfg.ext_m1[0][CW-1:0]))
        else $error("coordinate beyond configured extent");

endmodule

`default_nettype wire

// ===== design/lattice_neighbor_index_generator.sv =====
// Top level of the lattice neighbor index generator.
//
//   Port group     Direction  Handshake            Payload
//   input items    in         i_valid / o_stall    i_restart
//   result items   out        o_valid / i_stall    o_site_index, o_fwd_nb_*, o_bwd_nb_*,
//                                                  o_on_boundary, o_last_site
//   configuration  in/out     APB psel / penable   paddr, pwdata, prdata
//
// One site per cycle while items are not held off: each transfer is turned into a result
// in a single pass of adds and compares and lands in the result register in the cycle after it.
// A stalled result only holds off new items while the result register is full.
// After reset and after every write to a listed register, items are held off
// while the stride multiplier chain settles.
// Reset sets four dimensions of extent four and puts the walk at site 0.
`default_nettype none

module lattice_neighbor_index_generator
    import lng_pkg::*;
#(
    parameter int MAX_DIMS   = LNG_MAX_DIMS,
    parameter int MAX_EXTENT = LNG_MAX_EXTENT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_restart,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [SITE_W-1:0] o_site_index,
    output logic      [SITE_W-1:0] o_fwd_nb_1,
    output logic      [SITE_W-1:0] o_fwd_nb_2,
    output logic      [SITE_W-1:0] o_fwd_nb_3,
    output logic      [SITE_W-1:0] o_fwd_nb_4,
    output logic      [SITE_W-1:0] o_bwd_nb_1,
    output logic      [SITE_W-1:0] o_bwd_nb_2,
    output logic      [SITE_W-1:0] o_bwd_nb_3,
    output logic      [SITE_W-1:0] o_bwd_nb_4,
    output logic                   o_on_boundary,
    output logic                   o_last_site
);

    t_lat_cfg                        cfg;
    logic [NUM_EXT-1:0][SITE_W-1:0]  fwd_nb;
    logic [NUM_EXT-1:0][SITE_W-1:0]  bwd_nb;

    // Registers and lattice geometry.
    lng_cfg #(
        .MAX_DIMS   (MAX_DIMS),
        .MAX_EXTENT (MAX_EXTENT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Site walker and result register.
    lng_step #(
        .MAX_DIMS   (MAX_DIMS),
        .MAX_EXTENT (MAX_EXTENT)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .i_restart     (i_restart),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_site_index  (o_site_index),
        .o_fwd_nb      (fwd_nb),
        .o_bwd_nb      (bwd_nb),
        .o_on_boundary (o_on_boundary),
        .o_last_site   (o_last_site)
    );

    assign o_fwd_nb_1 = fwd_nb[0];
    assign o_fwd_nb_2 = fwd_nb[1];
    assign o_fwd_nb_3 = fwd_nb[2];
    assign o_fwd_nb_4 = fwd_nb[3];
    assign o_bwd_nb_1 = bwd_nb[0];
    assign o_bwd_nb_2 = bwd_nb[1];
    assign o_bwd_nb_3 = bwd_nb[2];
    assign o_bwd_nb_4 = bwd_nb[3];

endmodule

`default_nettype wire

// ===== tb/lng_site_checker.sv =====
// Checker that predicts every lattice site result and compares it with the block's output.
module lng_site_checker
    import lng_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic                          i_pready,
    input  wire logic [ADDR_W-1:0]             i_paddr,
    input  wire logic [DATA_W-1:0]             i_pwdata,
    input  wire logic                          i_item_valid,
    input  wire logic                          i_item_stall,
    input  wire logic                          i_item_restart,
    input  wire logic                          i_result_valid,
    input  wire logic                          i_result_stall,
    input  wire logic [SITE_W-1:0]             i_site_index,
    input  wire logic [NUM_EXT-1:0][SITE_W-1:0] i_fwd_nb,
    input  wire logic [NUM_EXT-1:0][SITE_W-1:0] i_bwd_nb,
    input  wire logic                          i_on_boundary,
    input  wire logic                          i_last_site,
    output int                                 o_mismatches,
    output int                                 o_pending
);

    // One expected result: the site and its neighbor table entry.
    typedef struct packed {
        logic [SITE_W-1:0]               site;
        logic [NUM_EXT-1:0][SITE_W-1:0]  fwd;
        logic [NUM_EXT-1:0][SITE_W-1:0]  bwd;
        logic                            boundary;
        logic                            last;
    } t_site_row;

    // Shadow of the register file and of the walk position.
    logic [DIMS_W-1:0]             cfg_dims;
    logic [NUM_EXT-1:0][EXT_W-1:0] cfg_ext;
    logic [NUM_EXT-1:0][3:0]       walk_coord;
    logic [REG_IDX_W-1:0]          widx;

    t_site_row expected_rows[$];
    t_site_row row;
    int        mismatch_cnt = 0;
    int        result_no    = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // Clamp the extent register to the range the lattice supports.
    function automatic logic [31:0] eff_extent(input logic [EXT_W-1:0] e);
        if (e == 0) return 32'd1;
        if (e > LNG_MAX_EXTENT) return LNG_MAX_EXTENT;
        return 32'(e);
    endfunction

    // Computes the neighbor table entry of the current site, then steps the walk on.
    function automatic t_site_row neighbor_row_and_step();
        t_site_row   r;
        int unsigned nd;
        logic [31:0] stride [NUM_EXT+1];
        logic [31:0] site;
        logic [31:0] e;
        logic [31:0] c;
        logic [31:0] f;
        logic [31:0] b;
        logic        carry;
        r    = '0;
        nd   = (cfg_dims == 0) ? 1 : (cfg_dims > LNG_MAX_DIMS) ? LNG_MAX_DIMS : cfg_dims;
        site = 0;
        stride[0] = 1;
        for (int k = 0; k < nd; k++) begin
            stride[k+1] = stride[k] * eff_extent(cfg_ext[k]);
            site        = site + 32'(walk_coord[k]) * stride[k];
        end
        r.last = 1'b1;
        for (int k = 0; k < nd; k++) begin
            e = eff_extent(cfg_ext[k]);
            c = 32'(walk_coord[k]);
            f = site + stride[k];
            b = site + stride[k+1] - stride[k];
            if (c == e - 1) begin
                f          = f - stride[k+1];
                r.boundary = 1'b1;
            end else begin
                r.last = 1'b0;
            end
            if (c != 0) begin
                b = b - stride[k+1];
            end else begin
                r.boundary = 1'b1;
            end
            r.fwd[k] = f[SITE_W-1:0];
            r.bwd[k] = b[SITE_W-1:0];
        end
        r.site = site[SITE_W-1:0];
        // Odometer step with carry into the next active dimension.
        carry = 1'b1;
        for (int k = 0; k < nd; k++) begin
            if (carry) begin
                if (32'(walk_coord[k]) + 1 < eff_extent(cfg_ext[k])) begin
                    walk_coord[k] = walk_coord[k] + 4'd1;
                    carry         = 1'b0;
                end else begin
                    walk_coord[k] = 4'd0;
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [SITE_W-1:0] want,
                                        input logic [SITE_W-1:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("result %0d field %s: expected %0h, got %0h", result_no, name, want, got);
            end
        end
    endfunction

    // Track register writes, check each result transfer, predict each item transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_dims   = 3'd4;
            cfg_ext    = {NUM_EXT{5'd4}};
            walk_coord = '0;
            expected_rows.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                widx = i_paddr[ADDR_W-1:2];
                case (widx)
                    REG_DIMS: begin
                        cfg_dims   = i_pwdata[DIMS_W-1:0];
                        walk_coord = '0;
                    end
                    REG_EXT_D1, REG_EXT_D2, REG_EXT_D3, REG_EXT_D4: begin
                        cfg_ext[widx - 1'b1] = i_pwdata[EXT_W-1:0];
                        walk_coord           = '0;
                    end
                    default: ;
                endcase
            end

            if (i_result_valid && !i_result_stall) begin
                if (expected_rows.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("result %0d arrived with no item waiting: site %0h",
                                 result_no, i_site_index);
                    end
                end else begin
                    row = expected_rows.pop_front();
                    check_field("site_index", row.site, i_site_index);
                    for (int k = 0; k < NUM_EXT; k++) begin
                        check_field($sformatf("fwd_nb_%0d", k + 1), row.fwd[k], i_fwd_nb[k]);
                        check_field($sformatf("bwd_nb_%0d", k + 1), row.bwd[k], i_bwd_nb[k]);
                    end
                    check_field("on_boundary", 16'(row.boundary), 16'(i_on_boundary));
                    check_field("last_site", 16'(row.last), 16'(i_last_site));
                end
                result_no++;
            end

            if (i_item_valid && !i_item_stall) begin
                if (i_item_restart) walk_coord = '0;
                expected_rows.push_back(neighbor_row_and_step());
            end
        end
        o_pending    <= expected_rows.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

// ===== tb/lattice_neighbor_index_generator_test.sv =====
// Stimulus and verdict for the lattice neighbor index generator.
module lattice_neighbor_index_generator_test;
    import lng_pkg::*;

    localparam int ITEMS          = 800;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;

    // Indexes past the register list; writes there must leave the walk alone.
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic              item_valid   = 1'b0;
    logic              item_restart = 1'b0;
    logic              result_stall = 1'b0;
    logic              hold_request = 1'b0;

    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              item_stall;
    logic              result_valid;
    logic [SITE_W-1:0] site_index;
    logic [SITE_W-1:0] fwd_nb_1, fwd_nb_2, fwd_nb_3, fwd_nb_4;
    logic [SITE_W-1:0] bwd_nb_1, bwd_nb_2, bwd_nb_3, bwd_nb_4;
    logic              on_boundary;
    logic              last_site;

    int mismatches;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lattice_neighbor_index_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (item_valid),
        .o_stall       (item_stall),
        .i_restart     (item_restart),
        .o_valid       (result_valid),
        .i_stall       (result_stall),
        .o_site_index  (site_index),
        .o_fwd_nb_1    (fwd_nb_1),
        .o_fwd_nb_2    (fwd_nb_2),
        .o_fwd_nb_3    (fwd_nb_3),
        .o_fwd_nb_4    (fwd_nb_4),
        .o_bwd_nb_1    (bwd_nb_1),
        .o_bwd_nb_2    (bwd_nb_2),
        .o_bwd_nb_3    (bwd_nb_3),
        .o_bwd_nb_4    (bwd_nb_4),
        .o_on_boundary (on_boundary),
        .o_last_site   (last_site)
    );

    lng_site_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_item_valid   (item_valid),
        .i_item_stall   (item_stall),
        .i_item_restart (item_restart),
        .i_result_valid (result_valid),
        .i_result_stall (result_stall),
        .i_site_index   (site_index),
        .i_fwd_nb       ({fwd_nb_4, fwd_nb_3, fwd_nb_2, fwd_nb_1}),
        .i_bwd_nb       ({bwd_nb_4, bwd_nb_3, bwd_nb_2, bwd_nb_1}),
        .i_on_boundary  (on_boundary),
        .i_last_site    (last_site),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // Result side: random stalls, or one long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end else if (hold_request) begin
            result_stall <= 1'b1;
            hold_left    <= HOLD_CYCLES;
        end else begin
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Register write: setup cycle, access cycle, then the bus returns to idle.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        logic [DATA_W-1:0] data;
        data = val;
        if (idx <= REG_EXT_D4 && $urandom_range(0, 3) == 0) begin
            data = val | ($urandom & ~((idx == REG_DIMS) ? 32'h7 : 32'h1F));
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one item after a random gap and returns at the edge of its transfer.
    task automatic send_site(input logic restart);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_valid   <= 1'b0;
            item_restart <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
        item_valid   <= 1'b1;
        item_restart <= restart;
        @(posedge i_clk);
        while (item_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int          sent;
        int          n;
        int          r;
        logic [31:0] v;
        bit          hold_done;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset lattice of four by four by four by four, with a restart in the middle.
        send_site(1'b0);
        send_site(1'b0);
        send_site(1'b0);
        send_site(1'b1);
        send_site(1'b0);
        wait_drained();

        // Zero dimensions read as one, extent one: every site is its own neighbor.
        apb_write(REG_DIMS, 32'd0);
        apb_write(REG_EXT_D1, 32'd1);
        send_site(1'b0);
        send_site(1'b0);
        wait_drained();

        // Oversized values clamp; the full volume of 4096 sites fits the 16-bit indices.
        apb_write(REG_DIMS, 32'hFFFF_FFFF);
        apb_write(REG_EXT_D1, 32'd16);
        apb_write(REG_EXT_D2, 32'hFFFF_FFFF);
        apb_write(REG_EXT_D3, 32'd0);
        apb_write(REG_EXT_D4, 32'd17);
        send_site(1'b0);
        send_site(1'b0);
        send_site(1'b1);
        wait_drained();

        // Two by three lattice walked past its last site.
        apb_write(REG_DIMS, 32'd2);
        apb_write(REG_EXT_D1, 32'd2);
        apb_write(REG_EXT_D2, 32'd3);
        apb_write(REG_EXT_D3, 32'd5);
        repeat (7) send_site(1'b0);
        wait_drained();

        // Writes past the register list keep the walk where it is.
        apb_write(REG_SPARE_LO, $urandom);
        apb_write(REG_SPARE_HI, $urandom);
        repeat (3) send_site(1'b0);

        // Random phases with three idling profiles.
        sent      = 0;
        hold_done = 1'b0;
        while (sent < ITEMS) begin
            wait_drained();
            if (sent < ITEMS / 3) begin
                send_idle_pct   = 32;
                recv_stall_pct <= 71;
            end else if (sent < 2 * ITEMS / 3) begin
                send_idle_pct   = 71;
                recv_stall_pct <= 32;
            end else begin
                send_idle_pct   = 0;
                recv_stall_pct <= 0;
            end

            case ($urandom_range(0, 4))
                0: ;
                1: apb_write(REG_SPARE_LO + 3'($urandom_range(0, 2)), $urandom);
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 85) begin
                        v = $urandom_range(1, 4);
                    end else begin
                        v = $urandom_range(0, 3);
                        if (v != 0) v = v + 4;
                    end
                    apb_write(REG_DIMS, v);
                    for (int k = 0; k < NUM_EXT; k++) begin
                        r = $urandom_range(0, 99);
                        if (r < 60) v = $urandom_range(1, 4);
                        else if (r < 80) v = $urandom_range(5, 16);
                        else if (r < 90) v = $urandom_range(0, 1);
                        else v = $urandom_range(17, 31);
                        apb_write(REG_EXT_D1 + 3'(k), v);
                    end
                end
            endcase

            // Once, stall the results for a long stretch while items keep coming.
            if (!hold_done && sent >= 2 * ITEMS / 3) hold_request <= 1'b1;

            n = $urandom_range(20, 60);
            repeat (n) begin
                send_site($urandom_range(0, 19) == 0);
                sent++;
                if (hold_request) begin
                    hold_request <= 1'b0;
                    hold_done     = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
